// File: hdl/mcsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_pkg
// Types, constants and helpers shared by the multi-channel slew limiter.
// ----------------------------------------------------------------------------
package mcsl_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 10;
  localparam int unsigned CHAN_W           = 4;
  localparam int unsigned SPEED_W          = 8;
  localparam int unsigned RATE_W           = 8;
  localparam int unsigned REQ_W            = 16;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 8'sd127;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -8'sd127;
  localparam logic        [RATE_W-1:0]  RESET_RATE = 8'd10;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_RATE   = 2'd2,
    KIND_KILL   = 2'd3
  } kind_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                      kill;
    logic                      wr_tgt;
    logic                      imm;
    logic                      wr_rate;
    logic [CHAN_W-1:0]         chan;
    logic signed [SPEED_W-1:0] speed;
    logic [RATE_W-1:0]         rate;
  } cmd_t;

  // One drive write travelling down the result chain.
  typedef struct packed {
    logic                      valid;
    logic [CHAN_W-1:0]         port;
    logic signed [SPEED_W-1:0] speed;
    logic                      last;
  } res_t;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [REQ_W-1:0] req
  );
    logic signed [SPEED_W-1:0] s;
    if (req > REQ_W'(SPEED_MAX)) begin
      s = SPEED_MAX;
    end else if (req < REQ_W'(SPEED_MIN)) begin
      s = SPEED_MIN;
    end else begin
      s = req[SPEED_W-1:0];
    end
    return s;
  endfunction

endpackage

// File: hdl/mcsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_cell
// One channel of the limiter: holds current speed, target and step rate, and
// performs the slew step or the kill when the walk token reaches it.
// ----------------------------------------------------------------------------
module mcsl_cell
  import mcsl_pkg::*;
#(
  parameter int unsigned CH_IDX = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic tok_i,
  output logic tok_o,
  input  logic later_i,
  output logic later_o,
  input  res_t res_i,
  output res_t res_o
);

  localparam logic [CHAN_W-1:0] Idx = CHAN_W'(CH_IDX);

  logic signed [SPEED_W-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [RATE_W-1:0]         rate_q, rate_d;
  logic                      tok_q;

  logic                      hit;
  logic                      pending;
  logic signed [SPEED_W:0]   diff;
  logic [SPEED_W-1:0]        gap;
  logic signed [SPEED_W+1:0] up, dn;
  logic signed [SPEED_W-1:0] moved;
  logic signed [SPEED_W-1:0] new_speed;

  assign hit     = (cmd_i.chan == Idx);
  assign pending = cmd_i.kill || (cur_q != tgt_q);
  assign later_o = later_i || pending;
  assign tok_o   = tok_q;

  // The gap between two clamped speeds never exceeds 254, so 8 bits hold it.
  assign diff = (SPEED_W+1)'(tgt_q) - (SPEED_W+1)'(cur_q);
  assign gap  = diff[SPEED_W] ? SPEED_W'(-diff) : diff[SPEED_W-1:0];
  assign up   = (SPEED_W+2)'(cur_q) + (SPEED_W+2)'({2'b00, rate_q});
  assign dn   = (SPEED_W+2)'(cur_q) - (SPEED_W+2)'({2'b00, rate_q});

  always_comb begin
    if (gap > rate_q) begin
      moved = diff[SPEED_W] ? dn[SPEED_W-1:0] : up[SPEED_W-1:0];
    end else begin
      moved = tgt_q;
    end
    new_speed = cmd_i.kill ? '0 : moved;
  end

  always_comb begin
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    rate_d = rate_q;
    if (tok_q) begin
      cur_d = new_speed;
      if (cmd_i.kill) begin
        tgt_d = '0;
      end
    end else begin
      if (cmd_i.wr_tgt && hit) begin
        tgt_d = cmd_i.speed;
        if (cmd_i.imm) begin
          cur_d = cmd_i.speed;
        end
      end
      if (cmd_i.wr_rate && hit) begin
        rate_d = cmd_i.rate;
      end
    end
  end

  // The cell holding the token drives the chain when its channel is pending; others pass it along.
  always_comb begin
    if (tok_q && pending) begin
      res_o.valid = 1'b1;
      res_o.port  = Idx + CHAN_W'(1);
      res_o.speed = new_speed;
      res_o.last  = !later_i;
    end else begin
      res_o = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      tgt_q  <= '0;
      rate_q <= RESET_RATE;
      tok_q  <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      rate_q <= rate_d;
      tok_q  <= tok_i;
    end
  end

endmodule

// File: hdl/multi_channel_slew_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_slew_limiter_top
// Slew-rate limiter for a row of motor channels, one cell per channel.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Fields
// command  in         start, busy          kind, channel, speed_request,
//                                          immediate, rate
// drive    out        strobe_o (no stall)  motor_port, drive_speed, last
//
// Set target and set rate leave busy low, so the next word may follow in the
// next cycle. An immediate write appears in the cycle after it is accepted.
// Tick and kill pass a token down the cell row, one cell per cycle, and busy
// stays high while a cell holds it; each write appears in the cycle after
// its cell is visited. Reset restores all cells at once, no clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_slew_limiter_top
  import mcsl_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind_i,
  input  logic [CHAN_W-1:0]         channel_i,
  input  logic signed [REQ_W-1:0]   speed_request_i,
  input  logic                      immediate_i,
  input  logic [RATE_W-1:0]         rate_i,
  output logic                      strobe_o,
  output logic [CHAN_W-1:0]         motor_port_o,
  output logic signed [SPEED_W-1:0] drive_speed_o,
  output logic                      last_o
);

  logic                      accept;
  kind_e                     kind;
  logic                      walk_start;
  logic                      chan_ok;
  logic                      imm_hit;
  logic signed [SPEED_W-1:0] clamped;
  logic                      kill_q, kill_d;
  cmd_t                      cmd;
  res_t                      res_q, res_d;

  logic [NUM_CHANNELS-1:0]   tok;
  logic [NUM_CHANNELS-1:0]   later;
  res_t                      chain [NUM_CHANNELS+1];

  assign kind       = kind_e'(kind_i);
  assign accept     = start && !busy;
  assign busy       = |tok;
  assign walk_start = accept && (kind == KIND_TICK || kind == KIND_KILL);
  assign chan_ok    = ({1'b0, channel_i} < (CHAN_W+1)'(NUM_CHANNELS));
  assign clamped    = clamp_speed(speed_request_i);
  assign imm_hit    = accept && (kind == KIND_TARGET) && immediate_i && chan_ok;
  assign kill_d     = walk_start ? (kind == KIND_KILL) : kill_q;

  always_comb begin
    cmd.kill    = kill_q;
    cmd.wr_tgt  = accept && (kind == KIND_TARGET);
    cmd.imm     = immediate_i;
    cmd.wr_rate = accept && (kind == KIND_RATE);
    cmd.chan    = channel_i;
    cmd.speed   = clamped;
    cmd.rate    = rate_i;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    logic tok_in;
    logic later_in;
    if (i == 0) begin : g_head
      assign tok_in = walk_start;
    end else begin : g_body
      assign tok_in = tok[i-1];
    end
    if (i == NUM_CHANNELS - 1) begin : g_tail
      assign later_in = 1'b0;
    end else begin : g_inner
      assign later_in = later[i+1];
    end
    mcsl_cell #(
      .CH_IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .tok_i  (tok_in),
      .tok_o  (tok[i]),
      .later_i(later_in),
      .later_o(later[i]),
      .res_i  (chain[i]),
      .res_o  (chain[i+1])
    );
  end

  always_comb begin
    if (imm_hit) begin
      res_d.valid = 1'b1;
      res_d.port  = channel_i + CHAN_W'(1);
      res_d.speed = clamped;
      res_d.last  = 1'b1;
    end else begin
      res_d = chain[NUM_CHANNELS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      kill_q <= 1'b0;
    end else begin
      res_q  <= res_d;
      kill_q <= kill_d;
    end
  end

  assign strobe_o      = res_q.valid;
  assign motor_port_o  = res_q.port;
  assign drive_speed_o = res_q.speed;
  assign last_o        = res_q.last;

`ifndef ASSERT_OFF
  // At most one cell holds the walk token.
  a_tok_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("walk token held by more than one cell");

  // A tick or kill must start a walk.
  a_walk_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_start |=> busy)
    else $error("walk did not start");

  // A non-final write means the walk still has cells to visit.
  a_more_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("write without last after the walk ended");

  // A kill walk writes every channel, so the first cell always reports.
  a_kill_writes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok[0] && kill_q) |=> (strobe_o && drive_speed_o == '0))
    else $error("kill walk missed a write");

  // Drive speeds stay inside the clamped range.
  a_speed_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (drive_speed_o != -8'sd128))
    else $error("drive speed out of range");
`endif

endmodule
